@@ rtl/lpfr_pkg.sv @@
package lpfr_pkg;

	localparam int unsigned ByteW  = 8;
	localparam int unsigned LenW   = 16;
	localparam int unsigned StatW  = 3;
	localparam int unsigned CfgIdxW = 8;
	localparam int unsigned CfgDatW = 16;

	// register indexes on the configuration port
	localparam logic [CfgIdxW-1:0] RegFrameId   = 8'd0;
	localparam logic [CfgIdxW-1:0] RegMaxLength = 8'd1;

	localparam logic [ByteW-1:0] FrameIdReset   = 8'd117;
	localparam logic [LenW-1:0]  MaxLengthReset = 16'd256;

	// frame status codes
	localparam logic [StatW-1:0] StBusy    = 3'd0;
	localparam logic [StatW-1:0] StOk      = 3'd1;
	localparam logic [StatW-1:0] StBadId   = 3'd2;
	localparam logic [StatW-1:0] StTooLong = 3'd3;
	localparam logic [StatW-1:0] StBadSum  = 3'd4;

	typedef struct packed {
		logic [ByteW-1:0] frame_id;
		logic [LenW-1:0]  max_length;
	} cfg_t;

	typedef struct packed {
		logic             payload_valid;
		logic [LenW-1:0]  payload_index;
		logic [ByteW-1:0] payload_byte;
		logic             frame_end;
		logic [StatW-1:0] status;
	} result_t;

endpackage

@@ rtl/lpfr_if.sv @@
interface lpfr_byte_if;
	logic                         valid;
	logic                         ready;
	logic [lpfr_pkg::ByteW-1:0]   rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

interface lpfr_result_if;
	logic                         valid;
	logic                         ready;
	logic                         payload_valid;
	logic [lpfr_pkg::LenW-1:0]    payload_index;
	logic [lpfr_pkg::ByteW-1:0]   payload_byte;
	logic                         frame_end;
	logic [lpfr_pkg::StatW-1:0]   status;

	modport source (output valid, output payload_valid, output payload_index,
		output payload_byte, output frame_end, output status, input ready);
	modport sink (input valid, input payload_valid, input payload_index,
		input payload_byte, input frame_end, input status, output ready);
endinterface

interface lpfr_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [lpfr_pkg::CfgIdxW-1:0]  index;
	logic [lpfr_pkg::CfgDatW-1:0]  data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

@@ rtl/lpfr_cfg_regs.sv @@
module lpfr_cfg_regs (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         wr_en,
	input  logic [lpfr_pkg::CfgIdxW-1:0] wr_index,
	input  logic [lpfr_pkg::CfgDatW-1:0] wr_data,
	output lpfr_pkg::cfg_t               cfg
);

	logic [lpfr_pkg::ByteW-1:0] frame_id_q;
	logic [lpfr_pkg::LenW-1:0]  max_length_q;

	// unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_id_q   <= lpfr_pkg::FrameIdReset;
			max_length_q <= lpfr_pkg::MaxLengthReset;
		end else if (wr_en) begin
			unique case (wr_index)
				lpfr_pkg::RegFrameId:   frame_id_q   <= wr_data[lpfr_pkg::ByteW-1:0];
				lpfr_pkg::RegMaxLength: max_length_q <= wr_data[lpfr_pkg::LenW-1:0];
				default: ;
			endcase
		end
	end

	assign cfg.frame_id   = frame_id_q;
	assign cfg.max_length = max_length_q;

endmodule

@@ rtl/lpfr_parser.sv @@
module lpfr_parser (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       step,
	input  logic [lpfr_pkg::ByteW-1:0] rx_byte,
	input  lpfr_pkg::cfg_t             cfg,
	output lpfr_pkg::result_t          result
);

	localparam logic [2:0] PhWaitId = 3'd0;
	localparam logic [2:0] PhLenHi  = 3'd1;
	localparam logic [2:0] PhLenLo  = 3'd2;
	localparam logic [2:0] PhData   = 3'd3;
	localparam logic [2:0] PhCheck  = 3'd4;

	logic [2:0]                 phase_q, phase_d;
	logic [lpfr_pkg::LenW-1:0]  len_q, len_d;
	logic [lpfr_pkg::LenW-1:0]  count_q, count_d;
	logic [lpfr_pkg::ByteW-1:0] sum_q, sum_d;
	logic [lpfr_pkg::LenW-1:0]  full_len;
	logic [lpfr_pkg::LenW:0]    count_inc;

	assign full_len  = {len_q[lpfr_pkg::LenW-1:lpfr_pkg::ByteW], rx_byte};
	assign count_inc = {1'b0, count_q} + {{lpfr_pkg::LenW{1'b0}}, 1'b1};

	always_comb begin
		phase_d = phase_q;
		len_d   = len_q;
		count_d = count_q;
		sum_d   = sum_q;
		result  = '0;
		result.status = lpfr_pkg::StBusy;
		unique case (phase_q)
			PhLenHi: begin
				len_d   = {rx_byte, {lpfr_pkg::ByteW{1'b0}}};
				phase_d = PhLenLo;
			end
			PhLenLo: begin
				len_d   = full_len;
				count_d = '0;
				if (full_len > cfg.max_length) begin
					result.frame_end = 1'b1;
					result.status    = lpfr_pkg::StTooLong;
					phase_d          = PhWaitId;
				end else if (full_len == '0) begin
					phase_d = PhCheck;
				end else begin
					phase_d = PhData;
				end
			end
			PhData: begin
				sum_d                = sum_q + rx_byte;
				result.payload_valid = 1'b1;
				result.payload_index = count_q;
				result.payload_byte  = rx_byte;
				if (count_inc >= {1'b0, len_q}) begin
					count_d = '0;
					phase_d = PhCheck;
				end else begin
					count_d = count_inc[lpfr_pkg::LenW-1:0];
				end
			end
			PhCheck: begin
				result.frame_end = 1'b1;
				result.status    = (sum_q == rx_byte) ? lpfr_pkg::StOk : lpfr_pkg::StBadSum;
				phase_d          = PhWaitId;
			end
			default: begin
				// waiting for id; unused codes land here too
				if (rx_byte == cfg.frame_id) begin
					sum_d   = '0;
					count_d = '0;
					phase_d = PhLenHi;
				end else begin
					result.frame_end = 1'b1;
					result.status    = lpfr_pkg::StBadId;
					phase_d          = PhWaitId;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PhWaitId;
			len_q   <= '0;
			count_q <= '0;
			sum_q   <= '0;
		end else if (step) begin
			phase_q <= phase_d;
			len_q   <= len_d;
			count_q <= count_d;
			sum_q   <= sum_d;
		end
	end

endmodule

@@ rtl/length_prefixed_frame_receiver.sv @@
// length-prefixed frame receiver: takes one received byte per item and parses frames of
// id byte, length high, length low, payload bytes, additive checksum byte; every item gives
// exactly one result item: payload bytes come out with their index, and the closing byte of
// a frame (or the byte that aborts it: wrong id, length above max_length) carries frame_end
// with the status; after any end the block waits for the next id on its own. an item goes
// through an input register and then a result register, from which its result is presented,
// and one item per cycle is sustained as long as the result side keeps ready high; the
// parser's frame state updates once per item. registers: index 0 is frame_id, index 1 is
// max_length; other indexes are ignored. write them only while idle.
module length_prefixed_frame_receiver (
	input  logic          clk,
	input  logic          arst_n,
	lpfr_byte_if.sink     rx,
	lpfr_result_if.source res,
	lpfr_cfg_if.sink      cfg
);

	lpfr_pkg::cfg_t    cfg_regs;
	lpfr_pkg::result_t result;
	lpfr_pkg::result_t result_s2;

	logic                       valid_s1;
	logic [lpfr_pkg::ByteW-1:0] byte_s1;
	logic                       valid_s2;
	logic                       adv_s1;

	// config writes are always taken
	assign cfg.ready = 1'b1;

	lpfr_cfg_regs u_cfg_regs (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg.valid),
		.wr_index (cfg.index),
		.wr_data  (cfg.data),
		.cfg      (cfg_regs)
	);

	// stage 1 moves into the result register when that slot is free or being drained
	assign adv_s1   = valid_s1 && (!valid_s2 || res.ready);
	assign rx.ready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.ready) begin
			valid_s1 <= rx.valid;
		end
	end

	// input byte register, no reset needed
	always_ff @(posedge clk) begin
		if (rx.ready && rx.valid) begin
			byte_s1 <= rx.rx_byte;
		end
	end

	// frame state advances exactly once per item, when it enters the result register
	lpfr_parser u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (adv_s1),
		.rx_byte (byte_s1),
		.cfg     (cfg_regs),
		.result  (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || res.ready) begin
			valid_s2 <= valid_s1;
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (adv_s1) begin
			result_s2 <= result;
		end
	end

	assign res.valid         = valid_s2;
	assign res.payload_valid = result_s2.payload_valid;
	assign res.payload_index = result_s2.payload_index;
	assign res.payload_byte  = result_s2.payload_byte;
	assign res.frame_end     = result_s2.frame_end;
	assign res.status        = result_s2.status;

endmodule

@@ sim/frame_parse_checker.sv @@
`timescale 1ns / 1ps

module frame_parse_checker
	import lpfr_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	lpfr_byte_if   rx,
	lpfr_result_if res,
	lpfr_cfg_if    cfg,
	output int     pending,
	output int     errors
);

	typedef enum logic [2:0] {WaitId, LenHi, LenLo, Payload, Checksum} parse_phase_t;

	parse_phase_t     parse_phase;
	cfg_t             regs;
	logic [LenW-1:0]  frame_len;
	logic [LenW-1:0]  byte_cnt;
	logic [ByteW-1:0] sum;
	result_t          expected_results[$];

	// advance the frame parser by one received byte and give the result it causes
	function automatic result_t parse_rx_byte(input logic [ByteW-1:0] b);
		result_t r;
		r = '0;
		r.status = StBusy;
		case (parse_phase)
			LenHi: begin
				frame_len = {b, 8'h00};
				parse_phase = LenLo;
			end
			LenLo: begin
				frame_len[7:0] = b;
				byte_cnt = '0;
				if (frame_len > regs.max_length) begin
					r.frame_end = 1'b1;
					r.status = StTooLong;
					parse_phase = WaitId;
				end else if (frame_len == '0) begin
					parse_phase = Checksum;
				end else begin
					parse_phase = Payload;
				end
			end
			Payload: begin
				sum = sum + b;
				r.payload_valid = 1'b1;
				r.payload_index = byte_cnt;
				r.payload_byte = b;
				if ({1'b0, byte_cnt} + 17'd1 >= {1'b0, frame_len}) begin
					byte_cnt = '0;
					parse_phase = Checksum;
				end else begin
					byte_cnt = byte_cnt + 1'b1;
				end
			end
			Checksum: begin
				r.frame_end = 1'b1;
				r.status = (sum == b) ? StOk : StBadSum;
				parse_phase = WaitId;
			end
			default: begin
				if (b == regs.frame_id) begin
					sum = '0;
					byte_cnt = '0;
					parse_phase = LenHi;
				end else begin
					r.frame_end = 1'b1;
					r.status = StBadId;
					parse_phase = WaitId;
				end
			end
		endcase
		return r;
	endfunction

	task automatic compare_field(input string name, input int want, input int got);
		if (want != got) begin
			errors++;
			$display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		result_t seen;
		result_t want;
		if (!arst_n) begin
			parse_phase = WaitId;
			regs.frame_id = FrameIdReset;
			regs.max_length = MaxLengthReset;
			frame_len = '0;
			byte_cnt = '0;
			sum = '0;
			expected_results.delete();
			pending <= 0;
		end else begin
			if (res.valid && res.ready) begin
				seen.payload_valid = res.payload_valid;
				seen.payload_index = res.payload_index;
				seen.payload_byte = res.payload_byte;
				seen.frame_end = res.frame_end;
				seen.status = res.status;
				if (expected_results.size() == 0) begin
					errors++;
					$display("%0t ns: result with none expected, expected nothing, got %h",
						$time, seen);
				end else begin
					want = expected_results.pop_front();
					compare_field("payload_valid", want.payload_valid, seen.payload_valid);
					compare_field("payload_index", want.payload_index, seen.payload_index);
					compare_field("payload_byte", want.payload_byte, seen.payload_byte);
					compare_field("frame_end", want.frame_end, seen.frame_end);
					compare_field("status", want.status, seen.status);
				end
			end
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					RegFrameId:   regs.frame_id = cfg.data[ByteW-1:0];
					RegMaxLength: regs.max_length = cfg.data;
					default: ;
				endcase
			end
			if (rx.valid && rx.ready)
				expected_results.push_back(parse_rx_byte(rx.rx_byte));
			pending <= expected_results.size();
		end
	end

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
	import lpfr_pkg::*;

	localparam int ResetCycles   = 4;
	localparam int HoldCycles    = 300;   // long result-side hold-off
	localparam int WatchdogLimit = 3000;  // cycles with no handshake on any channel
	localparam int DrainCycles   = 4;     // margin past the two-stage pipeline

	// an index outside the register map, writes to it are dropped
	localparam logic [CfgIdxW-1:0] RegUnused = 8'hFF;

	// directed items under the reset settings (frame id 'u', max length 256)
	localparam logic [ByteW-1:0] DirectedSeq [24] = '{
		8'h00, 8'hFF,                                      // wrong id, both extremes
		FrameIdReset, 8'h00, 8'h02, 8'hFF, 8'h01, 8'h00,   // two bytes, sum wraps to zero
		FrameIdReset, 8'h00, 8'h00, 8'h00,                 // zero length, good checksum
		FrameIdReset, 8'h00, 8'h00, 8'h5A,                 // zero length, bad checksum
		FrameIdReset, 8'hFF, 8'hFF,                        // length far above the limit
		FrameIdReset, 8'h00, 8'h01, 8'h80, 8'h7F           // one byte, bad checksum
	};

	logic clk = 1'b0;
	logic arst_n;

	lpfr_byte_if   rx();
	lpfr_result_if res();
	lpfr_cfg_if    cfg();

	int pending;
	int errors;
	int sent;
	int idle_cycles;
	bit calm;       // no random idling on either side
	bit stall_req;  // asks the result side for one long hold-off

	// settings the block holds right now, so stimulus can build frames it accepts
	logic [ByteW-1:0] cur_id;
	logic [LenW-1:0]  cur_max;

	length_prefixed_frame_receiver dut (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx),
		.res    (res),
		.cfg    (cfg)
	);

	frame_parse_checker frame_check (
		.clk     (clk),
		.arst_n  (arst_n),
		.rx      (rx),
		.res     (res),
		.cfg     (cfg),
		.pending (pending),
		.errors  (errors)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// result side: ready with a probability of about 94 percent, always in calm stretches,
	// and on request held low for a long stretch so the block backs up
	initial begin
		res.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (stall_req) begin
				stall_req = 1'b0;
				res.ready <= 1'b0;
				repeat (HoldCycles) @(negedge clk);
			end
			res.ready <= calm || ($urandom_range(99) >= 6);
		end
	end

	// ends a hung run: nothing moved on any channel for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((rx.valid && rx.ready) || (res.valid && res.ready) || (cfg.valid && cfg.ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WatchdogLimit) begin
				$display("%0t ns: no handshake for %0d cycles", $time, idle_cycles);
				$display("Test completed with failures");
				$finish;
			end
		end
	end

	// one item on the byte channel; called and returns at a falling edge,
	// leaves valid high so back-to-back items need no extra assignment
	task automatic send_byte(input logic [ByteW-1:0] b);
		while (!calm && $urandom_range(99) < 6) begin
			rx.valid <= 1'b0;
			@(negedge clk);
		end
		rx.valid <= 1'b1;
		rx.rx_byte <= b;
		do @(posedge clk); while (!(rx.valid && rx.ready));
		@(negedge clk);
		sent++;
	endtask

	// any byte except the frame id, so the parser stays waiting
	function automatic logic [ByteW-1:0] noise_byte();
		logic [ByteW-1:0] b;
		b = 8'($urandom);
		if (b == cur_id)
			b ^= 8'h01;
		return b;
	endfunction

	// full frame with random payload, checksum right or deliberately wrong
	task automatic send_frame(input int len, input bit sum_ok);
		logic [LenW-1:0]  l;
		logic [ByteW-1:0] s;
		logic [ByteW-1:0] b;
		l = 16'(len);
		s = '0;
		send_byte(cur_id);
		send_byte(l[15:8]);
		send_byte(l[7:0]);
		repeat (len) begin
			b = 8'($urandom);
			s += b;
			send_byte(b);
		end
		send_byte(sum_ok ? s : s ^ 8'($urandom_range(255, 1)));
	endtask

	// header whose length exceeds the limit, aborted on the length low byte
	task automatic send_too_long();
		logic [LenW-1:0] l;
		l = 16'($urandom_range(65535, int'(cur_max) + 1));
		send_byte(cur_id);
		send_byte(l[15:8]);
		send_byte(l[7:0]);
	endtask

	// frame cut short: the following items are eaten as payload and checksum
	task automatic send_broken_frame(input int lim);
		int len;
		int k;
		len = $urandom_range(lim, 1);
		k = $urandom_range(len - 1);
		send_byte(cur_id);
		send_byte(8'h00);
		send_byte(8'(len));
		repeat (k) send_byte(8'($urandom));
	endtask

	// mostly well-formed frames, with aborts, noise and truncated frames mixed in
	task automatic random_traffic(input int n);
		int stop;
		int kind;
		int lim;
		int len;
		stop = sent + n;
		lim = (cur_max < 20) ? int'(cur_max) : 20;
		while (sent < stop) begin
			kind = $urandom_range(99);
			if (kind < 12 && cur_max != 16'hFFFF) begin
				send_too_long();
			end else if (kind < 22) begin
				send_byte(noise_byte());
			end else if (kind < 30 && cur_max != 0 && cur_max <= 1024) begin
				// a huge limit would let a misparsed header start an endless frame
				send_broken_frame(lim);
			end else begin
				case ($urandom_range(5))
					0: len = 0;
					1: len = (cur_max <= 48) ? int'(cur_max) : lim;
					default: len = $urandom_range(lim);
				endcase
				send_frame(len, $urandom_range(3) != 0);
			end
		end
	endtask

	// register write; returns at a falling edge with valid still high
	task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDatW-1:0] value);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= value;
		do @(posedge clk); while (!(cfg.valid && cfg.ready));
		@(negedge clk);
	endtask

	// the frame id goes out with junk in the upper data bits, which must be dropped
	task automatic set_regs(input logic [ByteW-1:0] id, input logic [LenW-1:0] max_len);
		write_reg(RegFrameId, {8'($urandom), id});
		write_reg(RegMaxLength, max_len);
		cfg.valid <= 1'b0;
		cur_id = id;
		cur_max = max_len;
	endtask

	// stop sending and wait for every outstanding result, then choose how the
	// next phase idles; the flags change on a rising edge, away from the drivers
	task automatic settle(input bit calm_next, input bit stall_next);
		rx.valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (DrainCycles) @(posedge clk);
		calm = calm_next;
		stall_req = stall_next;
		@(negedge clk);
	endtask

	initial begin
		rx.valid = 1'b0;
		rx.rx_byte = '0;
		cfg.valid = 1'b0;
		cfg.index = '0;
		cfg.data = '0;
		calm = 1'b0;
		stall_req = 1'b0;
		cur_id = FrameIdReset;
		cur_max = MaxLengthReset;
		arst_n = 1'b0;
		repeat (ResetCycles) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (DirectedSeq[i])
			send_byte(DirectedSeq[i]);
		settle(1'b0, 1'b1);

		// small limit, with the long hold-off landing at its start
		set_regs(8'($urandom), 16'd16);
		random_traffic(140);
		settle(1'b1, 1'b0);

		// lowest settings, no idling anywhere: only zero-length frames pass
		set_regs(8'h00, 16'h0000);
		random_traffic(100);
		settle(1'b0, 1'b0);

		// highest settings, plus a write to an index outside the map
		write_reg(RegUnused, 16'($urandom));
		set_regs(8'hFF, 16'hFFFF);
		random_traffic(140);
		settle(1'b0, 1'b0);

		set_regs(8'($urandom), 16'($urandom_range(300, 1)));
		random_traffic(150);
		settle(1'b0, 1'b0);

		set_regs(FrameIdReset, MaxLengthReset);
		random_traffic(150);
		settle(1'b0, 1'b0);

		if (errors == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
